FILE: rtl/core/sukt_pkg.sv
package sukt_pkg;

  localparam int unsigned KeyW    = 31;
  localparam int unsigned HandleW = 16;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 7;

  typedef enum logic [1:0] {
    OP_INSERT_UNIQUE = 2'd0,
    OP_INSERT        = 2'd1,
    OP_READ          = 2'd2,
    OP_CLEAR         = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    STAT_INSERTED  = 3'd0,
    STAT_DUPLICATE = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_READ_OK   = 3'd3,
    STAT_RANGE     = 3'd4,
    STAT_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_INS_START,
    S_SHIFT,
    S_WRITE,
    S_RD_WAIT
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [KeyW-1:0]     key;
    logic [HandleW-1:0]  handle;
    logic [IndexW-1:0]   read_index;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [KeyW-1:0]     key_out;
    logic [HandleW-1:0]  handle_out;
    logic [PosW-1:0]     position;
    logic [CountW-1:0]   entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KeyW-1:0]     key;
    logic [HandleW-1:0]  handle;
  } entry_t;

endpackage

FILE: rtl/core/sorted_unique_key_table.sv
// Sorted key table: holds up to CAPACITY key/handle pairs in ascending key order in a
// single-port-read memory. An operation is taken when start is high and busy is low;
// its result appears on result_o for exactly one cycle, marked by done_o, and must be
// captured then. Clear and an out-of-range read give their result in the cycle after
// acceptance; a read in range passes through S_RD_WAIT. A plain insert passes through
// S_INS_START, then S_SHIFT if entries are stored, then S_WRITE; a unique insert first
// scans for a duplicate in S_SCAN. The scan reads one entry per cycle, then the shift
// moves one entry per cycle, both through the memory's single read port; the scan compares
// keys for equality and the shift compares them for less-than.
module sorted_unique_key_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  sukt_pkg::req_t cmd_i,
  output logic           busy,
  output logic           done_o,
  output sukt_pkg::rsp_t result_o
);

  import sukt_pkg::*;

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = (CntW > IndexW) ? CntW : IndexW;

  state_e              state_q, state_d;
  req_t                req_q, req_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [CntW-1:0]     cur_q, cur_d;
  logic                pend_q, pend_d;
  logic                done_q, done_d;
  rsp_t                rsp_q, rsp_d;

  logic                ram_we;
  logic [IdxW-1:0]     ram_waddr;
  entry_t              ram_wdata;
  logic [IdxW-1:0]     ram_raddr;
  entry_t              ram_rdata;

  logic                accept;
  logic                in_range;
  logic                dup_hit;
  logic                key_less;
  logic                full;
  logic [CntW-1:0]     cur_m1;
  logic [CntW-1:0]     cur_m2;
  logic [CntW-1:0]     count_m1;
  logic [CntW-1:0]     count_p1;

  function automatic rsp_t make_rsp(status_e s, logic [KeyW-1:0] k,
                                    logic [HandleW-1:0] h, logic [PosW-1:0] p,
                                    logic [CountW-1:0] c);
    rsp_t r;
    r.status      = s;
    r.key_out     = k;
    r.handle_out  = h;
    r.position    = p;
    r.entry_count = c;
    return r;
  endfunction

  assign accept   = start && (state_q == S_IDLE);
  assign busy     = (state_q != S_IDLE);
  assign in_range = CmpW'(cmd_i.read_index) < CmpW'(count_q);
  assign dup_hit  = pend_q && (ram_rdata.key == req_q.key);
  assign key_less = req_q.key < ram_rdata.key;
  assign full     = (count_q == CntW'(CAPACITY));
  assign cur_m1   = cur_q - CntW'(1);
  assign cur_m2   = cur_q - CntW'(2);
  assign count_m1 = count_q - CntW'(1);
  assign count_p1 = count_q + CntW'(1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (cmd_i.op)
            OP_INSERT_UNIQUE: state_d = S_SCAN;
            OP_INSERT:        state_d = S_INS_START;
            OP_READ:          state_d = in_range ? S_RD_WAIT : S_IDLE;
            OP_CLEAR:         state_d = S_IDLE;
            default:          state_d = S_IDLE;
          endcase
        end
      end
      S_SCAN: begin
        if (dup_hit) begin
          state_d = S_IDLE;
        end else if (cur_q == count_q) begin
          state_d = S_INS_START;
        end
      end
      S_INS_START: begin
        if (full) begin
          state_d = S_IDLE;
        end else if (count_q == '0) begin
          state_d = S_WRITE;
        end else begin
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!key_less || (cur_q == CntW'(1))) begin
          state_d = S_WRITE;
        end
      end
      S_WRITE:   state_d = S_IDLE;
      S_RD_WAIT: state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    req_d     = req_q;
    count_d   = count_q;
    cur_d     = cur_q;
    pend_d    = 1'b0;
    done_d    = 1'b0;
    rsp_d     = rsp_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q[IdxW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = cur_q[IdxW-1:0];
    unique case (state_q)
      S_IDLE: begin
        ram_raddr = IdxW'(cmd_i.read_index);
        if (accept) begin
          req_d = cmd_i;
          cur_d = '0;
          if (cmd_i.op == OP_CLEAR) begin
            count_d = '0;
            done_d  = 1'b1;
            rsp_d   = make_rsp(STAT_CLEARED, '0, '0, '0, '0);
          end else if ((cmd_i.op == OP_READ) && !in_range) begin
            done_d = 1'b1;
            rsp_d  = make_rsp(STAT_RANGE, '0, '0, '0, CountW'(count_q));
          end
        end
      end
      S_SCAN: begin
        if (dup_hit) begin
          done_d = 1'b1;
          rsp_d  = make_rsp(STAT_DUPLICATE, ram_rdata.key, ram_rdata.handle,
                            PosW'(cur_m1), CountW'(count_q));
        end else if (cur_q != count_q) begin
          cur_d  = cur_q + CntW'(1);
          pend_d = 1'b1;
        end
      end
      S_INS_START: begin
        ram_raddr = count_m1[IdxW-1:0];
        cur_d     = count_q;
        if (full) begin
          done_d = 1'b1;
          rsp_d  = make_rsp(STAT_FULL, req_q.key, req_q.handle, '0, CountW'(count_q));
        end
      end
      S_SHIFT: begin
        ram_raddr = cur_m2[IdxW-1:0];
        if (key_less) begin
          ram_we = 1'b1;
          cur_d  = cur_m1;
        end
      end
      S_WRITE: begin
        ram_we           = 1'b1;
        ram_wdata.key    = req_q.key;
        ram_wdata.handle = req_q.handle;
        count_d          = count_p1;
        done_d           = 1'b1;
        rsp_d            = make_rsp(STAT_INSERTED, req_q.key, req_q.handle,
                                    PosW'(cur_q), CountW'(count_p1));
      end
      S_RD_WAIT: begin
        done_d = 1'b1;
        rsp_d  = make_rsp(STAT_READ_OK, ram_rdata.key, ram_rdata.handle,
                          PosW'(req_q.read_index), CountW'(count_q));
      end
      default: begin
        done_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      cur_q   <= '0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cur_q   <= cur_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    rsp_q <= rsp_d;
  end

  sukt_ram #(
    .Width($bits(entry_t)),
    .Depth(CAPACITY)
  ) u_sukt_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign done_o   = done_q;
  assign result_o = rsp_q;

endmodule

FILE: rtl/core/sukt_ram.sv
module sukt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/sukt_checker.sv
module sukt_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input logic           done_o,
  input sukt_pkg::rsp_t result_o
);

  import sukt_pkg::*;

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o))
    else $error("accepted transfer made no progress");

  a_done_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy || start))
    else $error("result without a pending operation");

  a_busy_end_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o)
    else $error("operation ended without a result");

  a_insert_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((CAPACITY <= 64) && done_o && (result_o.status == STAT_INSERTED))
      |-> (CountW'(result_o.position) < result_o.entry_count))
    else $error("inserted position beyond entry count");

endmodule

bind sorted_unique_key_table sukt_checker #(
  .CAPACITY(CAPACITY)
) u_sukt_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .done_o  (done_o),
  .result_o(result_o)
);

FILE: sim/sorted_unique_key_table_tb.sv
module sorted_unique_key_table_tb;
  import sukt_pkg::*;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned TailCycles = 150;
  localparam logic [KeyW-1:0] KeyMax = '1;

  typedef enum int unsigned {
    POOL_TINY,
    POOL_NARROW,
    POOL_TOP,
    POOL_WIDE
  } key_pool_e;

  typedef struct {
    req_t        req;
    int unsigned idle_pct;
    bit          drain;
  } cmd_slot_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  req_t cmd = '0;
  logic busy;
  logic done_o;
  rsp_t result_o;

  cmd_slot_t cmd_q[$];
  rsp_t      table_rsp_q[$];

  logic [KeyW-1:0]    table_keys[TableDepth];
  logic [HandleW-1:0] table_handles[TableDepth];
  int unsigned        table_used = 0;

  int unsigned gen_used = 0;
  int unsigned gen_idle_pct = 0;
  bit          next_drain = 1'b0;

  int unsigned in_flight = 0;
  int unsigned accepted_count = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count = 0;
  int unsigned total_items = 0;

  sorted_unique_key_table #(
    .CAPACITY(TableDepth)
  ) u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .cmd_i   (cmd),
    .busy    (busy),
    .done_o  (done_o),
    .result_o(result_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t        o;
    int unsigned pos;
    bit          found;
    o = '0;
    found = 1'b0;
    case (r.op)
      OP_CLEAR: begin
        table_used = 0;
        o.status = STAT_CLEARED;
      end
      OP_READ: begin
        if (r.read_index < table_used) begin
          o.status = STAT_READ_OK;
          o.key_out = table_keys[r.read_index];
          o.handle_out = table_handles[r.read_index];
          o.position = r.read_index;
        end else begin
          o.status = STAT_RANGE;
        end
      end
      default: begin
        if (r.op == OP_INSERT_UNIQUE) begin
          for (int unsigned i = 0; i < table_used && !found; i++) begin
            if (table_keys[i] == r.key) begin
              found = 1'b1;
              o.status = STAT_DUPLICATE;
              o.key_out = table_keys[i];
              o.handle_out = table_handles[i];
              o.position = PosW'(i);
            end
          end
        end
        if (!found) begin
          if (table_used >= TableDepth) begin
            o.status = STAT_FULL;
            o.key_out = r.key;
            o.handle_out = r.handle;
          end else begin
            pos = table_used;
            while (pos > 0 && r.key < table_keys[pos-1]) begin
              table_keys[pos] = table_keys[pos-1];
              table_handles[pos] = table_handles[pos-1];
              pos--;
            end
            table_keys[pos] = r.key;
            table_handles[pos] = r.handle;
            table_used++;
            o.status = STAT_INSERTED;
            o.key_out = r.key;
            o.handle_out = r.handle;
            o.position = PosW'(pos);
          end
        end
      end
    endcase
    o.entry_count = CountW'(table_used);
    return o;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at result %0d: %s", results_seen, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    end
  endtask

  task automatic push_cmd(op_e op, logic [KeyW-1:0] key, logic [HandleW-1:0] handle,
                          logic [IndexW-1:0] idx);
    cmd_slot_t s;
    s.req.op = op;
    s.req.key = key;
    s.req.handle = handle;
    s.req.read_index = idx;
    s.idle_pct = gen_idle_pct;
    s.drain = next_drain;
    next_drain = 1'b0;
    cmd_q.push_back(s);
    case (op)
      OP_CLEAR: gen_used = 0;
      OP_READ: ;
      default: if (gen_used < TableDepth) gen_used++;
    endcase
  endtask

  function automatic logic [KeyW-1:0] pick_key(key_pool_e pool);
    case (pool)
      POOL_TINY:   return KeyW'($urandom_range(0, 15));
      POOL_NARROW: return KeyW'($urandom_range(0, 200));
      POOL_TOP:    return KeyMax - KeyW'($urandom_range(0, 15));
      default:     return KeyW'($urandom());
    endcase
  endfunction

  function automatic logic [IndexW-1:0] pick_index();
    if ($urandom_range(0, 4) == 0) return IndexW'($urandom_range(0, 63));
    return IndexW'($urandom_range(0, gen_used > 0 ? gen_used - 1 : 0));
  endfunction

  task automatic add_sequence(bit fill);
    int unsigned n;
    key_pool_e   pool;
    if ($urandom_range(0, 7) == 0) next_drain = 1'b1;
    if (!fill && $urandom_range(0, 9) >= 8) begin
      repeat ($urandom_range(1, 6)) begin
        push_cmd(op_e'($urandom_range(0, 3)), KeyW'($urandom()), HandleW'($urandom()),
                 IndexW'($urandom()));
      end
    end else begin
      pool = key_pool_e'($urandom_range(0, 3));
      if (fill) n = $urandom_range(64, 70);
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(20, 66);
      else n = $urandom_range(1, 12);
      if (fill || $urandom_range(0, 3) != 0) push_cmd(OP_CLEAR, '0, '0, '0);
      repeat (n) begin
        if ($urandom_range(0, 4) == 0) begin
          push_cmd(OP_READ, KeyW'($urandom()), HandleW'($urandom()), pick_index());
        end else begin
          push_cmd(op_e'($urandom_range(0, 1)), pick_key(pool), HandleW'($urandom()),
                   IndexW'($urandom()));
        end
      end
      repeat ($urandom_range(2, 8)) begin
        push_cmd(OP_READ, KeyW'($urandom()), HandleW'($urandom()), pick_index());
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    cmd_slot_t slot;
    if (!rst_ni) begin
      start <= 1'b0;
      cmd <= '0;
    end else begin
      if (start && !busy) begin
        table_rsp_q.push_back(apply_table_op(cmd));
        accepted_count++;
        in_flight++;
      end
      if (done_o && in_flight > 0) in_flight--;
      // hold the command while the block is busy
      if (!start || !busy) begin
        if (cmd_q.size() > 0 && (!cmd_q[0].drain || in_flight == 0) &&
            $urandom_range(0, 99) >= cmd_q[0].idle_pct) begin
          slot = cmd_q.pop_front();
          start <= 1'b1;
          cmd <= slot.req;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor_proc
    rsp_t want;
    if (rst_ni) begin
      if ((start && !busy) || done_o) stall_cycles = 0;
      else stall_cycles++;
      if (done_o) begin
        results_seen++;
        if (table_rsp_q.size() == 0) begin
          report_mismatch("result with no transfer pending");
        end else begin
          want = table_rsp_q.pop_front();
          check_field("status", 32'(result_o.status), 32'(want.status));
          check_field("key_out", 32'(result_o.key_out), 32'(want.key_out));
          check_field("handle_out", 32'(result_o.handle_out), 32'(want.handle_out));
          check_field("position", 32'(result_o.position), 32'(want.position));
          check_field("entry_count", 32'(result_o.entry_count), 32'(want.entry_count));
        end
      end
    end
  end

  initial begin
    wait (stall_cycles >= StallLimit);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    gen_idle_pct = 13;
    push_cmd(OP_READ, '0, '0, IndexW'(0));
    push_cmd(OP_READ, KeyMax, '1, IndexW'(63));
    push_cmd(OP_INSERT_UNIQUE, KeyMax, 16'hffff, '0);
    push_cmd(OP_INSERT_UNIQUE, '0, '0, '1);
    push_cmd(OP_INSERT_UNIQUE, '0, 16'h1234, '0);
    push_cmd(OP_INSERT, '0, 16'haaaa, '0);
    push_cmd(OP_INSERT, KeyMax, 16'h5555, '0);
    push_cmd(OP_INSERT_UNIQUE, KeyMax, 16'h0001, '0);
    push_cmd(OP_INSERT, KeyW'(32'h4000_0000), 16'h0f0f, '0);
    for (int unsigned i = 0; i < 6; i++) begin
      push_cmd(OP_READ, '0, '0, IndexW'(i));
    end
    push_cmd(OP_READ, '0, '0, IndexW'(63));
    push_cmd(OP_CLEAR, KeyMax, '1, '1);
    push_cmd(OP_READ, '0, '0, IndexW'(0));
    push_cmd(OP_INSERT_UNIQUE, KeyW'(32'h2aaa_aaaa), 16'h5555, '0);
    push_cmd(OP_READ, '0, '0, IndexW'(0));
    push_cmd(OP_CLEAR, '0, '0, '0);

    next_drain = 1'b1;
    add_sequence(1'b1);
    while (cmd_q.size() < 600) add_sequence(1'b0);
    gen_idle_pct = 83;
    next_drain = 1'b1;
    while (cmd_q.size() < 1200) add_sequence(1'b0);
    gen_idle_pct = 0;
    next_drain = 1'b1;
    while (cmd_q.size() < 1800) add_sequence(1'b0);
    total_items = cmd_q.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (accepted_count == total_items);
    wait (results_seen >= total_items);
    repeat (TailCycles) @(posedge clk_i);
    if (table_rsp_q.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", table_rsp_q.size()));
    end
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

FILE: sorted_unique_key_table.f
rtl/core/sukt_pkg.sv
rtl/core/sukt_ram.sv
rtl/core/sorted_unique_key_table.sv
rtl/core/sukt_checker.sv
sim/sorted_unique_key_table_tb.sv
